@@ design/assert_macros.svh @@
// Concurrent assertion helpers for the design folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check with no reset qualifier
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rcmc_pkg.sv @@
package rcmc_pkg;

   localparam int ThreshW = 11;
   localparam int DutyW   = 16;
   localparam int TicksW  = 24;
   localparam int LevelW  = 4;
   localparam int CapW    = 16;
   localparam int CmdW    = 8;
   localparam int DirW    = 2;
   localparam int OpW     = 2;
   localparam int EvW     = 4;
   localparam int CsrIdxW = 2;

   localparam logic [DirW-1:0] DIR_REV  = 2'd1;
   localparam logic [DirW-1:0] DIR_FWD  = 2'd2;
   localparam logic [DirW-1:0] DIR_STOP = 2'd3;

   localparam logic [CmdW-1:0] CMD_HELP   = 8'h68; // h
   localparam logic [CmdW-1:0] CMD_LEFT   = 8'h4C; // L
   localparam logic [CmdW-1:0] CMD_RIGHT  = 8'h52; // R
   localparam logic [CmdW-1:0] CMD_STOP   = 8'h53; // S
   localparam logic [CmdW-1:0] CMD_FWD    = 8'h4D; // M
   localparam logic [CmdW-1:0] CMD_REV    = 8'h6D; // m
   localparam logic [CmdW-1:0] CMD_FASTER = 8'h41; // A
   localparam logic [CmdW-1:0] CMD_SLOWER = 8'h61; // a
   localparam logic [CmdW-1:0] CMD_STEERL = 8'h3C; // <
   localparam logic [CmdW-1:0] CMD_STEERR = 8'h3E; // >
   localparam logic [CmdW-1:0] CMD_NORM   = 8'h4E; // N

   localparam logic [LevelW-1:0] LEVEL_MIN   = 4'd3;
   localparam logic [LevelW-1:0] LEVEL_MAX   = 4'd9;
   localparam logic [LevelW-1:0] LEVEL_RESET = 4'd5;
   localparam logic [DutyW-1:0]  DUTY_RESET  = 16'd32767;

   localparam logic [ThreshW-1:0] THRESH_RESET = 11'd15;
   localparam logic [DutyW-1:0]   STEP_RESET   = 16'd6553;
   localparam logic [TicksW-1:0]  TICKS_RESET  = 24'd1000;

   localparam logic [CsrIdxW-1:0] CSR_THRESH = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_STEP   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_TICKS  = 2'd2;

   typedef enum logic [OpW-1:0] {
      OP_COMMAND = 2'd0,
      OP_ECHO    = 2'd1,
      OP_TICK    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_STOP    = 2'd1,
      PH_REVERSE = 2'd2,
      PH_RIGHT   = 2'd3
   } phase_type;

   typedef enum logic [EvW-1:0] {
      EV_NONE    = 4'd0,
      EV_MAX     = 4'd1,
      EV_MIN     = 4'd2,
      EV_STOPPED = 4'd3,
      EV_FORWARD = 4'd4,
      EV_REVERSE = 4'd5,
      EV_AVOIDED = 4'd6,
      EV_HELP    = 4'd7,
      EV_SPEED   = 4'd8
   } ev_type;

   typedef struct packed {
      logic [ThreshW-1:0] near_threshold;
      logic [DutyW-1:0]   duty_step;
      logic [TicksW-1:0]  avoid_phase_ticks;
   } cfg_type;

   typedef struct packed {
      logic [DirW-1:0]    left_direction;
      logic [DirW-1:0]    right_direction;
      logic [DutyW-1:0]   duty_a;
      logic [DutyW-1:0]   duty_b;
      logic [LevelW-1:0]  speed_level;
      logic [ThreshW-1:0] range_value;
      logic [EvW-1:0]     event_code;
   } res_type;

endpackage

@@ design/rcmc_core.sv @@
module rcmc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [rcmc_pkg::OpW-1:0]    operation,
   input  logic [rcmc_pkg::CmdW-1:0]   command_byte,
   input  logic [rcmc_pkg::CapW-1:0]   capture_count,
   input  rcmc_pkg::cfg_type           cfg,
   output rcmc_pkg::res_type           result
);
   import rcmc_pkg::*;

   logic                 expect_falling_ff, expect_falling_in;
   logic [CapW-1:0]      rise_time_ff, rise_time_in;
   logic [ThreshW-1:0]   distance_ff, distance_in;
   logic                 reverse_ff, reverse_in;
   logic                 halted_ff, halted_in;
   logic [LevelW-1:0]    level_ff, level_in;
   logic [DutyW-1:0]     duty_a_ff, duty_a_in;
   logic [DutyW-1:0]     duty_b_ff, duty_b_in;
   logic [DirW-1:0]      left_ff, left_in;
   logic [DirW-1:0]      right_ff, right_in;
   phase_type            phase_ff, phase_in;
   logic [TicksW-1:0]    timer_ff, timer_in;

   logic [CapW-1:0]         width;
   logic [CapW+4:0]         width_x17;
   logic [LevelW+DutyW-1:0] level_x_step;
   logic [TicksW-1:0]       timer_inc;
   logic [DirW-1:0]         run_dir;
   ev_type                  ev;

   assign width        = capture_count - rise_time_ff;
   assign width_x17    = {width, 4'b0000} + {5'b00000, width};
   assign level_x_step = level_ff * cfg.duty_step;
   assign timer_inc    = timer_ff + 1'b1;

   always_comb begin
      expect_falling_in = expect_falling_ff;
      rise_time_in      = rise_time_ff;
      distance_in       = distance_ff;
      reverse_in        = reverse_ff;
      halted_in         = halted_ff;
      level_in          = level_ff;
      duty_a_in         = duty_a_ff;
      duty_b_in         = duty_b_ff;
      left_in           = left_ff;
      right_in          = right_ff;
      phase_in          = phase_ff;
      timer_in          = timer_ff;
      ev                = EV_NONE;
      run_dir           = reverse_ff ? DIR_REV : DIR_FWD;

      case (operation)
         OP_COMMAND: begin
            if (phase_ff == PH_IDLE && distance_ff > cfg.near_threshold) begin
               case (command_byte)
                  CMD_HELP: ev = EV_HELP;
                  CMD_LEFT: begin
                     right_in = DIR_STOP;
                     left_in  = run_dir;
                  end
                  CMD_RIGHT: begin
                     left_in  = DIR_STOP;
                     right_in = run_dir;
                  end
                  CMD_STOP: begin
                     halted_in = 1'b1;
                     left_in   = DIR_STOP;
                     right_in  = DIR_STOP;
                     ev        = EV_STOPPED;
                  end
                  CMD_FWD: begin
                     halted_in  = 1'b0;
                     reverse_in = 1'b0;
                     left_in    = DIR_FWD;
                     right_in   = DIR_FWD;
                     ev         = EV_FORWARD;
                  end
                  CMD_REV: begin
                     reverse_in = 1'b1;
                     left_in    = DIR_REV;
                     right_in   = DIR_REV;
                     ev         = EV_REVERSE;
                  end
                  CMD_FASTER: begin
                     if (level_ff < LEVEL_MAX) begin
                        level_in  = level_ff + 1'b1;
                        duty_a_in = duty_a_ff + cfg.duty_step;
                        duty_b_in = duty_b_ff + cfg.duty_step;
                        ev        = EV_SPEED;
                     end else begin
                        ev = EV_MAX;
                     end
                  end
                  CMD_SLOWER: begin
                     if (level_ff > LEVEL_MIN) begin
                        level_in  = level_ff - 1'b1;
                        duty_a_in = duty_a_ff - cfg.duty_step;
                        duty_b_in = duty_b_ff - cfg.duty_step;
                        ev        = EV_SPEED;
                     end else begin
                        ev = EV_MIN;
                     end
                  end
                  CMD_STEERL: begin
                     if (level_ff < LEVEL_MAX) begin
                        duty_a_in = duty_a_ff + cfg.duty_step;
                     end else begin
                        duty_b_in = duty_b_ff - cfg.duty_step;
                     end
                  end
                  CMD_STEERR: begin
                     if (level_ff < LEVEL_MAX) begin
                        duty_b_in = duty_b_ff + cfg.duty_step;
                     end else begin
                        duty_a_in = duty_a_ff - cfg.duty_step;
                     end
                  end
                  CMD_NORM: begin
                     duty_a_in = level_x_step[DutyW-1:0];
                     duty_b_in = level_x_step[DutyW-1:0];
                     ev        = EV_SPEED;
                  end
                  default: ev = EV_NONE;
               endcase
            end
         end
         OP_ECHO: begin
            if (!expect_falling_ff) begin
               rise_time_in      = capture_count;
               expect_falling_in = 1'b1;
            end else begin
               distance_in       = width_x17[CapW+4:10];
               expect_falling_in = 1'b0;
            end
         end
         OP_TICK: begin
            if (phase_ff == PH_IDLE) begin
               if (distance_ff <= cfg.near_threshold && !halted_ff) begin
                  left_in  = DIR_STOP;
                  right_in = DIR_STOP;
                  phase_in = PH_STOP;
                  timer_in = '0;
               end
            end else if (timer_inc >= cfg.avoid_phase_ticks) begin
               timer_in = '0;
               case (phase_ff)
                  PH_STOP: begin
                     reverse_in = 1'b1;
                     left_in    = DIR_REV;
                     right_in   = DIR_REV;
                     phase_in   = PH_REVERSE;
                  end
                  PH_REVERSE: begin
                     left_in  = DIR_STOP;
                     right_in = run_dir;
                     phase_in = PH_RIGHT;
                  end
                  default: begin
                     left_in  = DIR_STOP;
                     right_in = DIR_STOP;
                     phase_in = PH_IDLE;
                     ev       = EV_AVOIDED;
                  end
               endcase
            end else begin
               timer_in = timer_inc;
            end
         end
         default: ev = EV_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_falling_ff <= 1'b0;
         rise_time_ff      <= '0;
         distance_ff       <= '0;
         reverse_ff        <= 1'b0;
         halted_ff         <= 1'b1;
         level_ff          <= LEVEL_RESET;
         duty_a_ff         <= DUTY_RESET;
         duty_b_ff         <= DUTY_RESET;
         left_ff           <= DIR_STOP;
         right_ff          <= DIR_STOP;
         phase_ff          <= PH_IDLE;
         timer_ff          <= '0;
      end else if (fire) begin
         expect_falling_ff <= expect_falling_in;
         rise_time_ff      <= rise_time_in;
         distance_ff       <= distance_in;
         reverse_ff        <= reverse_in;
         halted_ff         <= halted_in;
         level_ff          <= level_in;
         duty_a_ff         <= duty_a_in;
         duty_b_ff         <= duty_b_in;
         left_ff           <= left_in;
         right_ff          <= right_in;
         phase_ff          <= phase_in;
         timer_ff          <= timer_in;
      end
   end

   assign result.left_direction  = left_in;
   assign result.right_direction = right_in;
   assign result.duty_a          = duty_a_in;
   assign result.duty_b          = duty_b_in;
   assign result.speed_level     = level_in;
   assign result.range_value     = distance_in;
   assign result.event_code      = ev;

endmodule

@@ design/rover_command_motor_controller.sv @@
// Two-motor rover controller.
// Request channel (req_valid / req_stall) carries one item per transfer: a
// command byte, an echo edge capture or a time tick, chosen by req_operation.
// Every accepted item yields exactly one response transfer on the rsp_
// channel, showing motor directions, duties, speed level, range and an
// event code after that item's update.
// Path: a request transfer fills the input register; the update logic then
// writes the result into the response register, which offers the response.
// Throughput: one item per cycle while rsp_stall is low; the whole update
// is a single pass of logic between the input register and the response
// register.
// When the receiver stalls, the response register holds and the input
// register keeps taking one further item; req_stall rises only when both
// are full and rsp_stall is high.
// Reset (synchronous, active high) empties both registers, restores the
// configuration defaults and puts the rover in the stopped state.
// Configuration: csr_we writes csr_wdata to register csr_index (0 range
// threshold, 1 duty step, 2 phase ticks); write only while no item is open.
`include "assert_macros.svh"

module rover_command_motor_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rcmc_pkg::OpW-1:0]      req_operation,
   input  logic [rcmc_pkg::CmdW-1:0]     req_command_byte,
   input  logic [rcmc_pkg::CapW-1:0]     req_capture_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rcmc_pkg::DirW-1:0]     rsp_left_direction,
   output logic [rcmc_pkg::DirW-1:0]     rsp_right_direction,
   output logic [rcmc_pkg::DutyW-1:0]    rsp_duty_a,
   output logic [rcmc_pkg::DutyW-1:0]    rsp_duty_b,
   output logic [rcmc_pkg::LevelW-1:0]   rsp_speed_level,
   output logic [rcmc_pkg::ThreshW-1:0]  rsp_range_value,
   output logic [rcmc_pkg::EvW-1:0]      rsp_event_code,
   input  logic                          csr_we,
   input  logic [rcmc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [rcmc_pkg::TicksW-1:0]   csr_wdata
);
   import rcmc_pkg::*;

   cfg_type          cfg_ff;
   logic             in_valid_ff;
   logic [OpW-1:0]   in_op_ff;
   logic [CmdW-1:0]  in_cmd_ff;
   logic [CapW-1:0]  in_cap_ff;
   logic             out_valid_ff;
   res_type          out_ff;
   res_type          result;
   logic             advance;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_threshold    <= THRESH_RESET;
         cfg_ff.duty_step         <= STEP_RESET;
         cfg_ff.avoid_phase_ticks <= TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESH: cfg_ff.near_threshold    <= csr_wdata[ThreshW-1:0];
            CSR_STEP:   cfg_ff.duty_step         <= csr_wdata[DutyW-1:0];
            CSR_TICKS:  cfg_ff.avoid_phase_ticks <= csr_wdata[TicksW-1:0];
            default:    cfg_ff                   <= cfg_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_op_ff  <= req_operation;
         in_cmd_ff <= req_command_byte;
         in_cap_ff <= req_capture_count;
      end
   end

   rcmc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .operation     (in_op_ff),
      .command_byte  (in_cmd_ff),
      .capture_count (in_cap_ff),
      .cfg           (cfg_ff),
      .result        (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_left_direction  = out_ff.left_direction;
   assign rsp_right_direction = out_ff.right_direction;
   assign rsp_duty_a          = out_ff.duty_a;
   assign rsp_duty_b          = out_ff.duty_b;
   assign rsp_speed_level     = out_ff.speed_level;
   assign rsp_range_value     = out_ff.range_value;
   assign rsp_event_code      = out_ff.event_code;

   `ASSERT_CLK(a_level_range, clock, reset, rsp_valid |-> (rsp_speed_level >= LEVEL_MIN && rsp_speed_level <= LEVEL_MAX), "speed level out of range")
   `ASSERT_CLK(a_avoided_stops, clock, reset, (rsp_valid && rsp_event_code == EV_AVOIDED) |-> (rsp_left_direction == DIR_STOP && rsp_right_direction == DIR_STOP), "avoidance end with motors running")
   `ASSERT_CLK(a_forward_dirs, clock, reset, (rsp_valid && rsp_event_code == EV_FORWARD) |-> (rsp_left_direction == DIR_FWD && rsp_right_direction == DIR_FWD), "forward event without forward drive")
   `ASSERT_CLK(a_reverse_dirs, clock, reset, (rsp_valid && rsp_event_code == EV_REVERSE) |-> (rsp_left_direction == DIR_REV && rsp_right_direction == DIR_REV), "reverse event without reverse drive")

endmodule

@@ dv/tb_rover_command_motor_controller.sv @@
`timescale 1ns / 100ps

import rcmc_pkg::*;

class rover_outputs_tracker;
   cfg_type            regs;
   bit                 falling_next;
   logic [CapW-1:0]    rise_cap;
   logic [ThreshW-1:0] range_q;
   bit                 reversing;
   bit                 halted_q;
   logic [LevelW-1:0]  level;
   logic [DutyW-1:0]   duty_a;
   logic [DutyW-1:0]   duty_b;
   logic [DirW-1:0]    left_dir;
   logic [DirW-1:0]    right_dir;
   phase_type          phase;
   int unsigned        phase_count;
   res_type            due_outputs[$];
   int unsigned        errors;
   int unsigned        checked;
   int unsigned        avoided;

   function new();
      regs.near_threshold    = THRESH_RESET;
      regs.duty_step         = STEP_RESET;
      regs.avoid_phase_ticks = TICKS_RESET;
      falling_next = 1'b0;
      rise_cap     = '0;
      range_q      = '0;
      reversing    = 1'b0;
      halted_q     = 1'b1;
      level        = LEVEL_RESET;
      duty_a       = DUTY_RESET;
      duty_b       = DUTY_RESET;
      left_dir     = DIR_STOP;
      right_dir    = DIR_STOP;
      phase        = PH_IDLE;
      phase_count  = 0;
      errors       = 0;
      checked      = 0;
      avoided      = 0;
   endfunction

   function void write_reg(logic [CsrIdxW-1:0] idx, logic [TicksW-1:0] data);
      case (idx)
         CSR_THRESH: regs.near_threshold    = data[ThreshW-1:0];
         CSR_STEP:   regs.duty_step         = data[DutyW-1:0];
         CSR_TICKS:  regs.avoid_phase_ticks = data;
         default: ;
      endcase
   endfunction

   function void drive_motors(bit run_left, bit run_right);
      logic [DirW-1:0] run;
      run       = reversing ? DIR_REV : DIR_FWD;
      left_dir  = run_left ? run : DIR_STOP;
      right_dir = run_right ? run : DIR_STOP;
   endfunction

   function void apply_item(logic [OpW-1:0] op, logic [CmdW-1:0] cmd, logic [CapW-1:0] cap);
      ev_type          ev;
      logic [CapW-1:0] width;
      res_type         want;
      ev = EV_NONE;
      case (op)
         OP_COMMAND: begin
            if (phase == PH_IDLE && range_q > regs.near_threshold) begin
               case (cmd)
                  CMD_HELP:  ev = EV_HELP;
                  CMD_LEFT:  drive_motors(1'b1, 1'b0);
                  CMD_RIGHT: drive_motors(1'b0, 1'b1);
                  CMD_STOP: begin
                     halted_q = 1'b1;
                     drive_motors(1'b0, 1'b0);
                     ev = EV_STOPPED;
                  end
                  CMD_FWD: begin
                     halted_q  = 1'b0;
                     reversing = 1'b0;
                     drive_motors(1'b1, 1'b1);
                     ev = EV_FORWARD;
                  end
                  CMD_REV: begin
                     reversing = 1'b1;
                     drive_motors(1'b1, 1'b1);
                     ev = EV_REVERSE;
                  end
                  CMD_FASTER: begin
                     if (level < LEVEL_MAX) begin
                        level  = level + 1'b1;
                        duty_a = duty_a + regs.duty_step;
                        duty_b = duty_b + regs.duty_step;
                        ev = EV_SPEED;
                     end else begin
                        ev = EV_MAX;
                     end
                  end
                  CMD_SLOWER: begin
                     if (level > LEVEL_MIN) begin
                        level  = level - 1'b1;
                        duty_a = duty_a - regs.duty_step;
                        duty_b = duty_b - regs.duty_step;
                        ev = EV_SPEED;
                     end else begin
                        ev = EV_MIN;
                     end
                  end
                  CMD_STEERL: begin
                     if (level < LEVEL_MAX) duty_a = duty_a + regs.duty_step;
                     else duty_b = duty_b - regs.duty_step;
                  end
                  CMD_STEERR: begin
                     if (level < LEVEL_MAX) duty_b = duty_b + regs.duty_step;
                     else duty_a = duty_a - regs.duty_step;
                  end
                  CMD_NORM: begin
                     duty_a = level * regs.duty_step;
                     duty_b = duty_a;
                     ev = EV_SPEED;
                  end
                  default: ;
               endcase
            end
         end
         OP_ECHO: begin
            if (!falling_next) begin
               rise_cap     = cap;
               falling_next = 1'b1;
            end else begin
               width        = cap - rise_cap;
               range_q      = ThreshW'((17 * 32'(width)) >> 10);
               falling_next = 1'b0;
            end
         end
         OP_TICK: begin
            if (phase == PH_IDLE) begin
               if (range_q <= regs.near_threshold && !halted_q) begin
                  drive_motors(1'b0, 1'b0);
                  phase       = PH_STOP;
                  phase_count = 0;
               end
            end else begin
               phase_count++;
               if (phase_count >= regs.avoid_phase_ticks) begin
                  phase_count = 0;
                  case (phase)
                     PH_STOP: begin
                        reversing = 1'b1;
                        drive_motors(1'b1, 1'b1);
                        phase = PH_REVERSE;
                     end
                     PH_REVERSE: begin
                        drive_motors(1'b0, 1'b1);
                        phase = PH_RIGHT;
                     end
                     default: begin
                        drive_motors(1'b0, 1'b0);
                        phase = PH_IDLE;
                        ev = EV_AVOIDED;
                     end
                  endcase
               end
            end
         end
         default: ;
      endcase
      want = '{left_dir, right_dir, duty_a, duty_b, level, range_q, ev};
      due_outputs.push_back(want);
   endfunction

   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function void compare_outputs(res_type got);
      res_type want;
      if (due_outputs.size() == 0) begin
         errors++;
         $display("%0t: response transfer with nothing outstanding", $time);
         return;
      end
      want = due_outputs.pop_front();
      checked++;
      if (want.event_code == EV_AVOIDED) avoided++;
      check_field("left_direction", want.left_direction, got.left_direction);
      check_field("right_direction", want.right_direction, got.right_direction);
      check_field("duty_a", want.duty_a, got.duty_a);
      check_field("duty_b", want.duty_b, got.duty_b);
      check_field("speed_level", want.speed_level, got.speed_level);
      check_field("range_value", want.range_value, got.range_value);
      check_field("event_code", want.event_code, got.event_code);
   endfunction
endclass

module tb_rover_command_motor_controller;

   localparam logic [OpW-1:0]     OP_UNUSED   = 2'd3;
   localparam logic [CmdW-1:0]    CMD_UNKNOWN = 8'hFF;
   localparam int unsigned        RANGE_MAX   = 1087;
   localparam int unsigned        IDLE_LIMIT  = 1000;

   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [OpW-1:0]       req_operation     = OP_COMMAND;
   logic [CmdW-1:0]      req_command_byte  = '0;
   logic [CapW-1:0]      req_capture_count = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [DirW-1:0]      rsp_left_direction;
   logic [DirW-1:0]      rsp_right_direction;
   logic [DutyW-1:0]     rsp_duty_a;
   logic [DutyW-1:0]     rsp_duty_b;
   logic [LevelW-1:0]    rsp_speed_level;
   logic [ThreshW-1:0]   rsp_range_value;
   logic [EvW-1:0]       rsp_event_code;
   logic                 csr_we            = 1'b0;
   logic [CsrIdxW-1:0]   csr_index         = CSR_THRESH;
   logic [TicksW-1:0]    csr_wdata         = '0;

   res_type              seen_result;
   rover_outputs_tracker tracker;
   int unsigned          items_sent    = 0;
   int unsigned          settings_used = 1;
   int unsigned          burst_left    = 0;
   int unsigned          rx_cycle      = 0;
   int unsigned          idle_cycles   = 0;
   int unsigned          stall_pct [4] = '{0, 20, 50, 85};
   logic [CmdW-1:0]      known_cmds [11] = '{CMD_HELP, CMD_LEFT, CMD_RIGHT, CMD_STOP, CMD_FWD,
                                             CMD_REV, CMD_FASTER, CMD_SLOWER, CMD_STEERL,
                                             CMD_STEERR, CMD_NORM};
   logic [CmdW-1:0]      opening_cmds [11] = '{CMD_HELP, CMD_LEFT, CMD_REV, CMD_RIGHT,
                                               CMD_SLOWER, CMD_SLOWER, CMD_SLOWER, CMD_STEERL,
                                               CMD_STEERR, CMD_NORM, CMD_UNKNOWN};

   rover_command_motor_controller DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_command_byte    (req_command_byte),
      .req_capture_count   (req_capture_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_left_direction  (rsp_left_direction),
      .rsp_right_direction (rsp_right_direction),
      .rsp_duty_a          (rsp_duty_a),
      .rsp_duty_b          (rsp_duty_b),
      .rsp_speed_level     (rsp_speed_level),
      .rsp_range_value     (rsp_range_value),
      .rsp_event_code      (rsp_event_code),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   assign seen_result = '{rsp_left_direction, rsp_right_direction, rsp_duty_a, rsp_duty_b,
                          rsp_speed_level, rsp_range_value, rsp_event_code};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // check on the pre-edge values, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) tracker.compare_outputs(seen_result);
         rx_cycle++;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct[(rx_cycle >> 7) % 4]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_item(input logic [OpW-1:0] op, input logic [CmdW-1:0] cmd,
                            input logic [CapW-1:0] cap);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_command_byte  <= cmd;
      req_capture_count <= cap;
      do @(posedge clock); while (!(req_valid && !req_stall));
      burst_left--;
      items_sent++;
      tracker.apply_item(op, cmd, cap);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (tracker.due_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input logic [ThreshW-1:0] thresh,
                               input logic [DutyW-1:0] duty_inc,
                               input logic [TicksW-1:0] ticks);
      logic [TicksW-1:0]  data [3];
      logic [CsrIdxW-1:0] idx [3];
      int                 k;
      drain_results();
      data = '{TicksW'(thresh), TicksW'(duty_inc), ticks};
      idx  = '{CSR_THRESH, CSR_STEP, CSR_TICKS};
      for (k = 0; k < 3; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= data[k];
         @(posedge clock);
         tracker.write_reg(idx[k], data[k]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic send_echo(input logic [CapW-1:0] width);
      logic [CapW-1:0] rise;
      rise = CapW'($urandom());
      // close a stray edge so the pair lands rising then falling
      if (tracker.falling_next) send_item(OP_ECHO, CmdW'($urandom()), CapW'($urandom()));
      send_item(OP_ECHO, CmdW'($urandom()), rise);
      send_item(OP_ECHO, CmdW'($urandom()), rise + width);
   endtask

   task automatic set_range(input bit far);
      int unsigned d;
      if (far && tracker.regs.near_threshold < RANGE_MAX)
         d = $urandom_range(tracker.regs.near_threshold + 1, RANGE_MAX);
      else
         d = $urandom_range(0, tracker.regs.near_threshold);
      send_echo(CapW'((d * 1024 + 16) / 17));
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned start;
      int unsigned choice;
      int unsigned n;
      int unsigned k;
      bit          paused;
      start  = items_sent;
      paused = 1'b0;
      while (items_sent - start < count) begin
         choice = $urandom_range(0, 99);
         if (choice < 35) begin
            set_range(1'b1);
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
               send_item(OP_COMMAND, known_cmds[$urandom_range(0, 10)], CapW'($urandom()));
         end else if (choice < 60) begin
            // avoidance run: go forward, get close, tick; every phase if ticks <= 3
            set_range(1'b1);
            send_item(OP_COMMAND, CMD_FWD, CapW'($urandom()));
            set_range(1'b0);
            n = (tracker.regs.avoid_phase_ticks > 3) ? 12 :
                3 * ((tracker.regs.avoid_phase_ticks == 0) ? 1 : tracker.regs.avoid_phase_ticks) + 1;
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 5) == 0)
                  send_item(OP_COMMAND, known_cmds[$urandom_range(0, 10)], CapW'($urandom()));
               send_item(OP_TICK, CmdW'($urandom()), CapW'($urandom()));
            end
         end else if (choice < 75) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) send_item(OP_TICK, CmdW'($urandom()), CapW'($urandom()));
         end else if (choice < 85) begin
            if ($urandom_range(0, 3) == 0) send_echo(CapW'($urandom()));
            else set_range($urandom_range(0, 1));
         end else begin
            send_item(OpW'($urandom_range(0, 3)), CmdW'($urandom()), CapW'($urandom()));
         end
         if (!paused && items_sent - start >= count / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      int k;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_TICK, 8'h00, 16'h0000);
      send_item(OP_COMMAND, CMD_STOP, 16'hFFFF);
      send_item(OP_ECHO, 8'hFF, 16'h0000);
      send_item(OP_ECHO, 8'h00, 16'hFFFF);
      for (k = 0; k < 11; k++) send_item(OP_COMMAND, opening_cmds[k], CapW'($urandom()));
      send_item(OP_UNUSED, CMD_FWD, CapW'($urandom()));
      for (k = 0; k < 7; k++) send_item(OP_COMMAND, CMD_FASTER, CapW'($urandom()));
      send_item(OP_COMMAND, CMD_STEERL, CapW'($urandom()));
      send_item(OP_COMMAND, CMD_STEERR, CapW'($urandom()));
      send_item(OP_COMMAND, CMD_STOP, CapW'($urandom()));
      send_item(OP_COMMAND, CMD_FWD, CapW'($urandom()));
      send_item(OP_ECHO, 8'h00, 16'hFFFF);
      send_item(OP_ECHO, 8'hFF, 16'h0000);
      send_item(OP_TICK, 8'h00, 16'h0000);
      send_item(OP_COMMAND, CMD_FWD, CapW'($urandom()));

      program_regs('0, '0, '0);
      run_random(70);
      program_regs(ThreshW'(RANGE_MAX), 16'hFFFF, 24'd1);
      run_random(50);
      program_regs(THRESH_RESET, STEP_RESET, 24'd2);
      run_random(70);
      program_regs(ThreshW'($urandom_range(0, RANGE_MAX)), DutyW'($urandom()), 24'd3);
      run_random(70);
      program_regs(11'd300, 16'h8000, 24'hFFFFFF);
      run_random(40);
      program_regs(ThreshW'($urandom_range(0, RANGE_MAX)), DutyW'($urandom()),
                   TicksW'($urandom_range(1, 4)));
      run_random(100);

      drain_results();
      repeat (8) @(posedge clock);
      $display("Run covered %0d request transfers under %0d register settings, %0d responses checked.",
               items_sent, settings_used, tracker.checked);
      $display("%0d avoidance manoeuvres completed, %0d mismatches.", tracker.avoided,
               tracker.errors);
      if (tracker.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
